// ===== hw/rtl/package_entry_allocator_unit_defines.svh =====
// Assertion macros for the entry allocator checker.
`ifndef PACKAGE_ENTRY_ALLOCATOR_UNIT_DEFINES_SVH
`define PACKAGE_ENTRY_ALLOCATOR_UNIT_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define PEA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define PEA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/pea_pkg.sv =====
// Types and codes shared by the entry allocator modules.
package pea_pkg;

	typedef enum logic [1:0] {
		MODE_ALLOC  = 2'd0,
		MODE_FREE   = 2'd1,
		MODE_LOOKUP = 2'd2,
		MODE_LOOKUP_ALT = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_CONFLICT  = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	localparam logic [1:0] CFG_MAX_ENTRIES = 2'd0;
	localparam logic [1:0] CFG_MIN_FRAG    = 2'd1;
	localparam logic [1:0] CFG_DATA_START  = 2'd2;

	localparam logic [10:0] MAX_ENTRIES_RST = 11'd1024;

	typedef struct packed {
		logic [31:0] key;
		logic [31:0] offset;
		logic [31:0] size;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_KEY_SCAN,
		S_FIT_SCAN,
		S_TGT_RD,
		S_WR_HIT,
		S_WR_TGT,
		S_WR_FRAG,
		S_REPORT
	} state_t;

endpackage

// ===== hw/rtl/pea_table_ram.sv =====
// Entry table memory: one write port, one registered read port.
module pea_table_ram #(
	parameter int DEPTH = 1024,
	parameter int AW = 10
) (
	input  logic            clk,
	input  logic            rd_en,
	input  logic [AW-1:0]   rd_addr,
	output pea_pkg::entry_t rd_data,
	input  logic            wr_en,
	input  logic [AW-1:0]   wr_addr,
	input  pea_pkg::entry_t wr_data
);

	pea_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/package_entry_allocator_unit.sv =====
// Entry allocator top level: command port, config registers, scan sequencer.
//
// Command transaction: raise start with mode, file_key and length; the
// transaction is taken at the edge where start is high and busy is low.
// Exactly one result follows, shown for one cycle with done high; the
// receiver cannot stall it, so capture it on that edge. The table sits in
// one memory with a single read port, scanned one entry per cycle. A lookup
// or a free scans the live entries for the key check; an allocate scans the
// live entries, then the fragments for the fit search, then does the swap
// into the live region. A successful free also swaps the freed entry out of
// the live region. No clearing pass runs after reset. A write to data_start
// has no effect: no register holds it, and the end pointer resets to zero.
module package_entry_allocator_unit #(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	// command
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [31:0] file_key,
	input  logic [31:0] length,
	// result
	output logic        done,
	output logic [1:0]  status,
	output logic [31:0] entry_offset,
	output logic [31:0] entry_size,
	output logic [10:0] live_total,
	output logic [31:0] bytes_used,
	// configuration
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [31:0] cfg_wdata
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	// Configuration registers.
	logic [10:0] max_entries_q;
	logic [31:0] min_frag_q;
	logic [CW-1:0] cap;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_entries_q <= pea_pkg::MAX_ENTRIES_RST;
			min_frag_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				pea_pkg::CFG_MAX_ENTRIES: max_entries_q <= cfg_wdata[10:0];
				pea_pkg::CFG_MIN_FRAG: min_frag_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Clamp the slot limit to the range 1 .. TABLE_DEPTH.
	always_comb begin
		if (max_entries_q == '0) begin
			cap = CW'(1);
		end else if (32'(max_entries_q) > 32'(TABLE_DEPTH)) begin
			cap = CW'(TABLE_DEPTH);
		end else begin
			cap = CW'(max_entries_q);
		end
	end

	// Sequencer and datapath state.
	pea_pkg::state_t state_q, state_nx;
	pea_pkg::mode_t mode_q;
	logic [31:0] key_q, len_q;
	logic [CW-1:0] live_q, slot_q, ptr_q, hi;
	logic [31:0] end_q, used_q;
	logic vld_s1;
	logic [AW-1:0] idx_s1;
	logic [AW-1:0] hit_q, tgt_q, frag_idx_q, min_idx_q;
	pea_pkg::entry_t ent_q, frag_q;
	logic split_q, have_min_q;
	logic [31:0] min_len_q;
	pea_pkg::status_t stat_q;
	logic done_q;
	pea_pkg::status_t status_q;
	logic [31:0] off_q, size_q;

	// Memory port.
	logic rd_en, wr_en;
	logic [AW-1:0] rd_addr, wr_addr;
	pea_pkg::entry_t rd_data, wr_data;

	logic scanning, hit_now, issue, scan_end;
	logic [CW-1:0] live_dec;
	logic [31:0] rem;

	assign scanning = (state_q == pea_pkg::S_KEY_SCAN) || (state_q == pea_pkg::S_FIT_SCAN);
	assign hi = (state_q == pea_pkg::S_KEY_SCAN) ? live_q : slot_q;
	assign hit_now = scanning && vld_s1 && ((state_q == pea_pkg::S_KEY_SCAN) ?
		(rd_data.key == key_q) : (rd_data.size >= len_q));
	assign issue = scanning && !hit_now && (ptr_q < hi);
	assign scan_end = scanning && !hit_now && !vld_s1 && !issue;
	assign live_dec = live_q - CW'(1);
	assign rem = rd_data.size - len_q;

	pea_table_ram #(
		.DEPTH(TABLE_DEPTH),
		.AW(AW)
	) u_ram (
		.clk(clk),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	// Next state.
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			pea_pkg::S_IDLE: begin
				if (start) state_nx = pea_pkg::S_KEY_SCAN;
			end
			pea_pkg::S_KEY_SCAN: begin
				if (hit_now) begin
					state_nx = (mode_q == pea_pkg::MODE_FREE) ? pea_pkg::S_TGT_RD
						: pea_pkg::S_REPORT;
				end else if (scan_end) begin
					if (mode_q == pea_pkg::MODE_ALLOC && live_q < cap) begin
						state_nx = pea_pkg::S_FIT_SCAN;
					end else begin
						state_nx = pea_pkg::S_REPORT;
					end
				end
			end
			pea_pkg::S_FIT_SCAN: begin
				if (hit_now) begin
					state_nx = pea_pkg::S_TGT_RD;
				end else if (scan_end) begin
					state_nx = (slot_q < cap || have_min_q) ? pea_pkg::S_TGT_RD
						: pea_pkg::S_REPORT;
				end
			end
			pea_pkg::S_TGT_RD: state_nx = pea_pkg::S_WR_HIT;
			pea_pkg::S_WR_HIT: state_nx = pea_pkg::S_WR_TGT;
			pea_pkg::S_WR_TGT: state_nx = split_q ? pea_pkg::S_WR_FRAG : pea_pkg::S_REPORT;
			pea_pkg::S_WR_FRAG: state_nx = pea_pkg::S_REPORT;
			pea_pkg::S_REPORT: state_nx = pea_pkg::S_IDLE;
			default: state_nx = pea_pkg::S_IDLE;
		endcase
	end

	// Memory controls: scan reads, then a read of the swap target and up to
	// three writes (displaced entry, new or freed entry, split-off fragment).
	always_comb begin
		rd_en = issue || (state_q == pea_pkg::S_TGT_RD);
		rd_addr = (state_q == pea_pkg::S_TGT_RD) ? tgt_q : ptr_q[AW-1:0];
		wr_en = 1'b0;
		wr_addr = hit_q;
		wr_data = rd_data;
		unique case (state_q)
			pea_pkg::S_WR_HIT: begin
				wr_en = 1'b1;
			end
			pea_pkg::S_WR_TGT: begin
				wr_en = 1'b1;
				wr_addr = tgt_q;
				wr_data = ent_q;
			end
			pea_pkg::S_WR_FRAG: begin
				wr_en = 1'b1;
				wr_addr = frag_idx_q;
				wr_data = frag_q;
			end
			default: ;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pea_pkg::S_IDLE;
			live_q <= '0;
			slot_q <= '0;
			end_q <= '0;
			used_q <= '0;
			vld_s1 <= 1'b0;
			done_q <= 1'b0;
			split_q <= 1'b0;
			have_min_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			done_q <= (state_q == pea_pkg::S_REPORT);
			vld_s1 <= issue;
			unique case (state_q)
				pea_pkg::S_IDLE: begin
					split_q <= 1'b0;
					have_min_q <= 1'b0;
				end
				pea_pkg::S_FIT_SCAN: begin
					if (vld_s1 && !hit_now && (!have_min_q || rd_data.size < min_len_q)) begin
						have_min_q <= 1'b1;
					end
					if (hit_now) begin
						if (rem > min_frag_q && slot_q < cap) begin
							split_q <= 1'b1;
							slot_q <= slot_q + CW'(1);
						end
					end else if (scan_end) begin
						// Append in a new slot, or reuse the smallest fragment.
						if (slot_q < cap) begin
							slot_q <= slot_q + CW'(1);
						end
						if (slot_q < cap || have_min_q) begin
							end_q <= end_q + len_q;
						end
					end
				end
				pea_pkg::S_WR_TGT: begin
					if (mode_q == pea_pkg::MODE_ALLOC) begin
						live_q <= live_q + CW'(1);
						used_q <= used_q + ent_q.size;
					end else begin
						live_q <= live_dec;
						used_q <= used_q - ent_q.size;
					end
				end
				default: ;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (scanning) begin
			idx_s1 <= ptr_q[AW-1:0];
			if (issue) ptr_q <= ptr_q + CW'(1);
		end
		unique case (state_q)
			pea_pkg::S_IDLE: begin
				if (start) begin
					mode_q <= pea_pkg::mode_t'(mode);
					key_q <= file_key;
					len_q <= length;
					ptr_q <= '0;
					stat_q <= pea_pkg::ST_OK;
				end
			end
			pea_pkg::S_KEY_SCAN: begin
				if (hit_now) begin
					if (mode_q == pea_pkg::MODE_ALLOC) begin
						stat_q <= pea_pkg::ST_CONFLICT;
					end
					hit_q <= idx_s1;
					tgt_q <= live_dec[AW-1:0];
					ent_q <= rd_data;
				end else if (scan_end) begin
					if (mode_q != pea_pkg::MODE_ALLOC) begin
						stat_q <= pea_pkg::ST_NOT_FOUND;
					end else if (live_q >= cap) begin
						stat_q <= pea_pkg::ST_FULL;
					end
					ptr_q <= live_q;
				end
			end
			pea_pkg::S_FIT_SCAN: begin
				if (vld_s1 && !hit_now && (!have_min_q || rd_data.size < min_len_q)) begin
					min_idx_q <= idx_s1;
					min_len_q <= rd_data.size;
				end
				tgt_q <= live_q[AW-1:0];
				if (hit_now) begin
					hit_q <= idx_s1;
					ent_q <= '{key: key_q, offset: rd_data.offset, size: len_q};
					frag_q <= '{key: key_q, offset: rd_data.offset + len_q, size: rem};
					frag_idx_q <= slot_q[AW-1:0];
				end else if (scan_end) begin
					ent_q <= '{key: key_q, offset: end_q, size: len_q};
					if (slot_q < cap) begin
						hit_q <= slot_q[AW-1:0];
					end else if (have_min_q) begin
						hit_q <= min_idx_q;
					end else begin
						stat_q <= pea_pkg::ST_FULL;
					end
				end
			end
			pea_pkg::S_REPORT: begin
				status_q <= stat_q;
				off_q <= (stat_q == pea_pkg::ST_OK) ? ent_q.offset : '0;
				size_q <= (stat_q == pea_pkg::ST_OK) ? ent_q.size : '0;
			end
			default: ;
		endcase
	end

	assign busy = (state_q != pea_pkg::S_IDLE);
	assign done = done_q;
	assign status = status_q;
	assign entry_offset = off_q;
	assign entry_size = size_q;
	assign live_total = 11'(live_q);
	assign bytes_used = used_q;

endmodule

// ===== hw/rtl/pea_checker.sv =====
// Port-level checker for the entry allocator, bound to the top level.
`include "package_entry_allocator_unit_defines.svh"

module pea_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [1:0]  status,
	input logic [31:0] entry_offset,
	input logic [31:0] entry_size
);

	`PEA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction did not raise busy")
	`PEA_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while still busy")
	`PEA_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe longer than one cycle")
	`PEA_ASSERT_NOW(a_fail_zero, done && status != pea_pkg::ST_OK, entry_offset == '0 && entry_size == '0, "failed request with nonzero payload")

endmodule

bind package_entry_allocator_unit pea_checker u_pea_checker (.*);
